/* sv/qsm_pkg.sv */
// ----------------------------------------------------------------------------
// qsm_pkg
// Shared types and codes for the queue / semaphore / mutex engine: request
// codes, object kinds, register indexes and the beat payloads of the channels.
// ----------------------------------------------------------------------------
package qsm_pkg;

  // fixed field widths of the channel payloads
  localparam int unsigned ITEM_W  = 32;
  localparam int unsigned TASK_W  = 8;
  localparam int unsigned CNT_W   = 7;
  localparam int unsigned SUM_W   = CNT_W + 1;
  localparam int unsigned CIDX_W  = 2;

  // register reset values
  localparam logic [CNT_W-1:0] CAPACITY_RST = 7'd64;
  localparam logic [CNT_W-1:0] INIT_CNT_RST = 7'd0;

  // request codes
  typedef enum logic [2:0] {
    REQ_SEND_BACK  = 3'd0,
    REQ_SEND_FRONT = 3'd1,
    REQ_OVERWRITE  = 3'd2,
    REQ_RECEIVE    = 3'd3,
    REQ_TAKE       = 3'd4,
    REQ_GIVE       = 3'd5,
    REQ_RESET      = 3'd6,
    REQ_STATUS     = 3'd7
  } req_type_e;

  // object kinds, code 3 is unused
  typedef enum logic [1:0] {
    KIND_QUEUE = 2'd0,
    KIND_SEM   = 2'd1,
    KIND_MUTEX = 2'd2
  } kind_e;

  // configuration register indexes, index 3 writes nothing
  typedef enum logic [CIDX_W-1:0] {
    CFG_OBJECT_KIND   = 2'd0,
    CFG_CAPACITY      = 2'd1,
    CFG_INITIAL_COUNT = 2'd2,
    CFG_NONE          = 2'd3
  } cfg_idx_e;

  typedef struct packed {
    req_type_e          req_type;
    logic [TASK_W-1:0]  requester;
    logic [ITEM_W-1:0]  item_data;
    logic               reset_is_new;
  } req_t;

  typedef struct packed {
    logic               ok;
    logic [ITEM_W-1:0]  item_out;
    logic [CNT_W-1:0]   waiting_count;
    logic [TASK_W-1:0]  holder;
    logic               wake;
  } rsp_t;

  typedef struct packed {
    logic [CIDX_W-1:0]  index;
    logic [CNT_W-1:0]   wdata;
  } cfg_t;

endpackage

/* sv/qsm_if.sv */
// ----------------------------------------------------------------------------
// qsm channel interfaces
// Valid/ready channels for requests, responses and register writes.
// ----------------------------------------------------------------------------
interface qsm_req_if;
  logic          valid;
  logic          ready;
  qsm_pkg::req_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface qsm_rsp_if;
  logic          valid;
  logic          ready;
  qsm_pkg::rsp_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface qsm_cfg_if;
  logic          valid;
  logic          ready;
  qsm_pkg::cfg_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

/* sv/queue_semaphore_mutex_engine_top.sv */
// ----------------------------------------------------------------------------
// queue_semaphore_mutex_engine_top
// One synchronisation object: message queue, counting semaphore or recursive
// mutex, chosen by a register.
//
// Channels: req_i takes one request beat (type, task id, item word, reset
// flag); rsp_o gives exactly one response beat per request, in order.
// cfg_i writes object_kind (0), capacity (1) or initial_count (2); any such
// write sets the object up afresh. cfg_i is always ready; write it only while
// no request is in flight.
// Path: response stage, then output register. Throughput: one request per
// cycle while rsp_o.ready is high. Control state sits in flops and is
// updated at acceptance; the item ring is a memory with one write or one
// registered read per request, so the next request never waits on it.
// Stalls: a response stage and an output register sit between the sides, so
// one more request is taken while a response waits; after that req_i.ready
// stays low until rsp_o.ready returns. The output beat holds while stalled.
// Reset: registers return to queue kind, capacity 64, initial count 0; the
// object is empty and unowned. The item ring is not cleared; a receive only
// reads entries that a send wrote.
// ----------------------------------------------------------------------------
module queue_semaphore_mutex_engine_top #(
  parameter int unsigned QUEUE_DEPTH = 64,
  parameter int unsigned ITEM_BITS   = 32,
  parameter int unsigned TASK_BITS   = 8,
  parameter int unsigned NEST_MAX    = 255
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  qsm_req_if.sink          req_i,
  qsm_rsp_if.source        rsp_o,
  qsm_cfg_if.sink          cfg_i
);

  localparam int unsigned IDX_W  = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned NEST_W = $clog2(NEST_MAX + 1);
  localparam int unsigned CNT_W  = qsm_pkg::CNT_W;
  localparam int unsigned SUM_W  = qsm_pkg::SUM_W;
  localparam logic [CNT_W-1:0] DEPTH_CAP =
    (QUEUE_DEPTH > 127) ? 7'd127 : CNT_W'(QUEUE_DEPTH);
  localparam logic [NEST_W-1:0] NEST_TOP = NEST_W'(NEST_MAX);

  // registers and object state
  logic [1:0]            kind_q;
  logic [CNT_W-1:0]      cap_q;
  logic [CNT_W-1:0]      init_q;
  logic [IDX_W-1:0]      head_q, head_d;
  logic [CNT_W-1:0]      cnt_q, cnt_d;
  logic [TASK_BITS-1:0]  owner_q, owner_d;
  logic [NEST_W-1:0]     nest_q, nest_d;

  // item ring
  logic [ITEM_BITS-1:0]  mem_q [QUEUE_DEPTH];
  logic [ITEM_BITS-1:0]  rd_q;

  // response stage and output register
  logic                  stg_valid_q;
  qsm_pkg::rsp_t         stg_q;
  logic                  stg_rx_q;
  logic                  out_valid_q;
  qsm_pkg::rsp_t         out_q;

  logic                  req_acc;
  logic                  cfg_acc;
  logic                  stg_move;

  // configuration next values
  logic [1:0]            kind_d;
  logic [CNT_W-1:0]      cap_d;
  logic [CNT_W-1:0]      init_d;
  logic [CNT_W-1:0]      eff_cap_d;
  logic [CNT_W-1:0]      setup_cnt;

  // request datapath
  qsm_pkg::req_t         req;
  logic [TASK_BITS-1:0]  who;
  logic [CNT_W-1:0]      eff_cap;
  logic [SUM_W-1:0]      head_ext, cnt_ext, cap_ext;
  logic [SUM_W-1:0]      head_inc, head_inc_w, tail, tail_w, head_dec;
  logic                  full;
  logic                  has_item;
  logic                  is_send;
  logic                  ok_c, wake_c, rx_c, wr_en_c, rd_en_c;
  logic [IDX_W-1:0]      wr_slot;
  logic [CNT_W-1:0]      waiting_c;
  qsm_pkg::rsp_t         rsp_c;

  assign req      = req_i.data;
  assign cfg_acc  = cfg_i.valid && cfg_i.ready;
  assign stg_move = stg_valid_q && (!out_valid_q || rsp_o.ready);
  assign req_acc  = req_i.valid && req_i.ready;

  assign cfg_i.ready = 1'b1;
  assign req_i.ready = !stg_valid_q || stg_move;
  assign rsp_o.valid = out_valid_q;
  assign rsp_o.data  = out_q;

  // register write decode and object setup values
  always_comb begin
    kind_d = kind_q;
    cap_d  = cap_q;
    init_d = init_q;
    unique case (cfg_i.data.index)
      qsm_pkg::CFG_OBJECT_KIND:   kind_d = cfg_i.data.wdata[1:0];
      qsm_pkg::CFG_CAPACITY:      cap_d  = cfg_i.data.wdata;
      qsm_pkg::CFG_INITIAL_COUNT: init_d = cfg_i.data.wdata;
      default: ;
    endcase
    eff_cap_d = (cap_d > DEPTH_CAP) ? DEPTH_CAP : cap_d;
    setup_cnt = '0;
    if (kind_d == qsm_pkg::KIND_SEM) begin
      setup_cnt = (init_d > eff_cap_d) ? eff_cap_d : init_d;
    end
  end

  // ring index arithmetic, wrap by one conditional subtract
  assign eff_cap    = (cap_q > DEPTH_CAP) ? DEPTH_CAP : cap_q;
  assign who        = TASK_BITS'(req.requester);
  assign head_ext   = SUM_W'(head_q);
  assign cnt_ext    = SUM_W'(cnt_q);
  assign cap_ext    = SUM_W'(eff_cap);
  assign head_inc   = head_ext + SUM_W'(1);
  assign head_inc_w = (head_inc >= cap_ext) ? head_inc - cap_ext : head_inc;
  assign tail       = head_ext + cnt_ext;
  assign tail_w     = (tail >= cap_ext) ? tail - cap_ext : tail;
  assign head_dec   = (head_q == '0) ? cap_ext - SUM_W'(1) : head_ext - SUM_W'(1);
  assign full       = cnt_q >= eff_cap;
  assign has_item   = (cnt_q != '0) && (eff_cap != '0);
  assign is_send    = (req.req_type == qsm_pkg::REQ_SEND_BACK) ||
                      (req.req_type == qsm_pkg::REQ_SEND_FRONT) ||
                      (req.req_type == qsm_pkg::REQ_OVERWRITE);

  // request decode and next object state
  always_comb begin
    head_d  = head_q;
    cnt_d   = cnt_q;
    owner_d = owner_q;
    nest_d  = nest_q;
    ok_c    = 1'b0;
    wake_c  = 1'b0;
    rx_c    = 1'b0;
    wr_en_c = 1'b0;
    rd_en_c = 1'b0;
    wr_slot = IDX_W'(tail_w);
    unique case (req.req_type)
      qsm_pkg::REQ_RESET: begin
        head_d  = '0;
        cnt_d   = '0;
        owner_d = '0;
        nest_d  = '0;
        ok_c    = 1'b1;
        wake_c  = !req.reset_is_new;
      end
      qsm_pkg::REQ_STATUS: begin
        ok_c = 1'b1;
      end
      default: begin
        unique case (kind_q)
          qsm_pkg::KIND_QUEUE: begin
            priority if (is_send) begin
              if ((eff_cap != '0) && (!full || req.req_type == qsm_pkg::REQ_OVERWRITE)) begin
                priority if (req.req_type == qsm_pkg::REQ_SEND_FRONT) begin
                  head_d  = IDX_W'(head_dec);
                  wr_slot = IDX_W'(head_dec);
                end else if (full) begin
                  // overwrite of the oldest item
                  wr_slot = head_q;
                  head_d  = IDX_W'(head_inc_w);
                end else begin
                  wr_slot = IDX_W'(tail_w);
                end
                if (!full) begin
                  cnt_d = cnt_q + CNT_W'(1);
                end
                wr_en_c = 1'b1;
                ok_c    = 1'b1;
              end
            end else if (req.req_type == qsm_pkg::REQ_RECEIVE) begin
              if (has_item) begin
                rd_en_c = 1'b1;
                rx_c    = 1'b1;
                head_d  = IDX_W'(head_inc_w);
                cnt_d   = cnt_q - CNT_W'(1);
                ok_c    = 1'b1;
              end
            end else begin
              ok_c = 1'b0;
            end
            wake_c = ok_c;
          end
          qsm_pkg::KIND_SEM: begin
            priority if (is_send || req.req_type == qsm_pkg::REQ_GIVE) begin
              if (!full) begin
                cnt_d = cnt_q + CNT_W'(1);
                ok_c  = 1'b1;
              end
            end else if (has_item) begin
              // take and receive both consume a token
              cnt_d = cnt_q - CNT_W'(1);
              ok_c  = 1'b1;
            end else begin
              ok_c = 1'b0;
            end
            wake_c = ok_c;
          end
          qsm_pkg::KIND_MUTEX: begin
            priority if (is_send || req.req_type == qsm_pkg::REQ_GIVE) begin
              if ((who != '0) && (owner_q == who) && (nest_q != '0)) begin
                nest_d = nest_q - NEST_W'(1);
                if (nest_q == NEST_W'(1)) begin
                  owner_d = '0;
                  cnt_d   = '0;
                end
                ok_c = 1'b1;
              end
              wake_c = ok_c;
            end else if (req.req_type == qsm_pkg::REQ_TAKE && who != '0) begin
              priority if (owner_q == who) begin
                if (nest_q < NEST_TOP) begin
                  nest_d = nest_q + NEST_W'(1);
                  ok_c   = 1'b1;
                end
              end else if (owner_q == '0 && cnt_q == '0) begin
                owner_d = who;
                nest_d  = NEST_W'(1);
                cnt_d   = CNT_W'(1);
                ok_c    = 1'b1;
              end else begin
                ok_c = 1'b0;
              end
            end else begin
              ok_c = 1'b0;
            end
          end
          default: ;
        endcase
      end
    endcase
  end

  // reported count after the request
  always_comb begin
    unique case (kind_q)
      qsm_pkg::KIND_QUEUE,
      qsm_pkg::KIND_SEM:   waiting_c = cnt_d;
      qsm_pkg::KIND_MUTEX: waiting_c = (cnt_d == '0) ? CNT_W'(1) : '0;
      default:             waiting_c = '0;
    endcase
    rsp_c.ok            = ok_c;
    rsp_c.item_out      = '0;
    rsp_c.waiting_count = waiting_c;
    rsp_c.holder        = qsm_pkg::TASK_W'(owner_d);
    rsp_c.wake          = wake_c;
  end

  // registers and object state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      kind_q  <= qsm_pkg::KIND_QUEUE;
      cap_q   <= qsm_pkg::CAPACITY_RST;
      init_q  <= qsm_pkg::INIT_CNT_RST;
      head_q  <= '0;
      cnt_q   <= '0;
      owner_q <= '0;
      nest_q  <= '0;
    end else if (cfg_acc) begin
      if (cfg_i.data.index != qsm_pkg::CFG_NONE) begin
        kind_q  <= kind_d;
        cap_q   <= cap_d;
        init_q  <= init_d;
        head_q  <= '0;
        cnt_q   <= setup_cnt;
        owner_q <= '0;
        nest_q  <= '0;
      end
    end else if (req_acc) begin
      head_q  <= head_d;
      cnt_q   <= cnt_d;
      owner_q <= owner_d;
      nest_q  <= nest_d;
    end
  end

  // item ring, one write or one registered read per request
  always_ff @(posedge clk_i) begin
    if (req_acc && wr_en_c) begin
      mem_q[wr_slot] <= ITEM_BITS'(req.item_data);
    end
    if (req_acc && rd_en_c) begin
      rd_q <= mem_q[head_q];
    end
  end

  // response stage and output register valids
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stg_valid_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (req_acc) begin
        stg_valid_q <= 1'b1;
      end else if (stg_move) begin
        stg_valid_q <= 1'b0;
      end
      if (stg_move) begin
        out_valid_q <= 1'b1;
      end else if (rsp_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // response payloads, read data joins at the output register
  always_ff @(posedge clk_i) begin
    if (req_acc) begin
      stg_q    <= rsp_c;
      stg_rx_q <= rx_c;
    end
    if (stg_move) begin
      out_q.ok            <= stg_q.ok;
      out_q.item_out      <= stg_rx_q ? qsm_pkg::ITEM_W'(rd_q) : '0;
      out_q.waiting_count <= stg_q.waiting_count;
      out_q.holder        <= stg_q.holder;
      out_q.wake          <= stg_q.wake;
    end
  end

endmodule

/* sv/qsm_checker.sv */
// ----------------------------------------------------------------------------
// qsm_checker
// Port-level checks on the engine's response beats, bound to the top level.
// ----------------------------------------------------------------------------
module qsm_checker (
  input logic          clk_i,
  input logic          rst_ni,
  input logic          rsp_valid_i,
  input logic          rsp_ready_i,
  input qsm_pkg::rsp_t rsp_data_i
);

  // a stalled response beat holds
  a_rsp_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && !rsp_ready_i |=> rsp_valid_i && $stable(rsp_data_i))
    else $error("response beat changed while stalled");

  // wake only follows a successful request
  a_wake_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && rsp_data_i.wake |-> rsp_data_i.ok)
    else $error("wake without success");

  // an item word is only returned by a successful receive
  a_item_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && (rsp_data_i.item_out != '0) |-> rsp_data_i.ok)
    else $error("item returned by a failed request");

  // an owned mutex is never reported free
  a_holder_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && (rsp_data_i.holder != '0) |-> (rsp_data_i.waiting_count == '0))
    else $error("mutex held but reported free");

endmodule

bind queue_semaphore_mutex_engine_top qsm_checker u_qsm_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .rsp_valid_i (rsp_o.valid),
  .rsp_ready_i (rsp_o.ready),
  .rsp_data_i  (rsp_o.data)
);

/* tb/sv/tb.sv */
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the queue / semaphore / mutex engine. A scripted
// run covers the corner cases of each object kind, then random phases drive
// mostly well-formed traffic with random idling on both channels. Each
// accepted request beat is run through a local predictor of the object and
// each response beat is compared field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module tb;

  localparam int unsigned CLK_PERIOD  = 8;
  localparam int unsigned QUEUE_DEPTH = 64;
  localparam int unsigned ITEM_BITS   = 32;
  localparam int unsigned TASK_BITS   = 8;
  localparam int unsigned NEST_MAX    = 255;
  localparam int unsigned STALL_LIMIT = 2000;
  localparam int unsigned DRAIN_CYCLES = 8;
  localparam int unsigned IDLE_PCT    = 19;
  localparam int unsigned CIDX_W      = qsm_pkg::CIDX_W;
  localparam int unsigned CNT_W       = qsm_pkg::CNT_W;
  localparam int unsigned ITEM_W      = qsm_pkg::ITEM_W;
  localparam int unsigned TASK_W      = qsm_pkg::TASK_W;

  // code the package leaves without a name
  localparam logic [1:0] KIND_UNUSED = 2'd3;

  typedef struct {
    bit                  is_reg;
    logic [CIDX_W-1:0]   reg_idx;
    logic [CNT_W-1:0]    reg_val;
    qsm_pkg::req_t       req;
    bit                  typed;
    qsm_pkg::rsp_t       want;
  } script_row_t;

  logic clk = 1'b0;
  logic rst_n;
  bit   calm = 1'b0;
  int unsigned mismatches = 0;
  int unsigned idle_cycles = 0;

  qsm_req_if req_ch ();
  qsm_rsp_if rsp_ch ();
  qsm_cfg_if cfg_ch ();

  queue_semaphore_mutex_engine_top #(
    .QUEUE_DEPTH (QUEUE_DEPTH),
    .ITEM_BITS   (ITEM_BITS),
    .TASK_BITS   (TASK_BITS),
    .NEST_MAX    (NEST_MAX)
  ) uut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .req_i  (req_ch),
    .rsp_o  (rsp_ch),
    .cfg_i  (cfg_ch)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  // predictor state: registers and object
  logic [1:0]        obj_kind;
  logic [CNT_W-1:0]  cap_reg;
  logic [CNT_W-1:0]  init_reg;
  logic [ITEM_W-1:0] ring [QUEUE_DEPTH];
  int unsigned       head;
  int unsigned       level;
  logic [TASK_W-1:0] owner;
  int unsigned       nesting;

  qsm_pkg::rsp_t due_rsps [$];
  script_row_t   script [$];

  function automatic int unsigned eff_capacity();
    return (cap_reg > QUEUE_DEPTH) ? QUEUE_DEPTH : cap_reg;
  endfunction

  // fresh object after reset or any register write
  function automatic void set_up_object();
    head    = 0;
    level   = 0;
    owner   = '0;
    nesting = 0;
    if (obj_kind == qsm_pkg::KIND_SEM)
      level = (init_reg > eff_capacity()) ? eff_capacity() : init_reg;
  endfunction

  // give on a semaphore or mutex
  function automatic bit release_token(input logic [TASK_W-1:0] who);
    if (obj_kind == qsm_pkg::KIND_SEM) begin
      if (level >= eff_capacity()) return 1'b0;
      level++;
      return 1'b1;
    end
    if (obj_kind == qsm_pkg::KIND_MUTEX) begin
      if (who == 0 || owner != who || nesting == 0) return 1'b0;
      nesting--;
      if (nesting == 0) begin
        owner = '0;
        level = 0;
      end
      return 1'b1;
    end
    return 1'b0;
  endfunction

  // apply one request to the object and work out its response beat
  function automatic qsm_pkg::rsp_t object_response(input qsm_pkg::req_t r);
    qsm_pkg::rsp_t o;
    int unsigned   cap;
    int unsigned   slot;
    o   = '0;
    cap = eff_capacity();
    if (r.req_type == qsm_pkg::REQ_RESET) begin
      head    = 0;
      level   = 0;
      owner   = '0;
      nesting = 0;
      o.ok    = 1'b1;
      o.wake  = !r.reset_is_new;
    end else if (r.req_type == qsm_pkg::REQ_STATUS) begin
      o.ok = 1'b1;
    end else if (obj_kind == qsm_pkg::KIND_QUEUE) begin
      if (r.req_type <= qsm_pkg::REQ_OVERWRITE) begin
        if (cap != 0 && (level < cap || r.req_type == qsm_pkg::REQ_OVERWRITE)) begin
          if (r.req_type == qsm_pkg::REQ_SEND_FRONT) begin
            head = (head == 0) ? cap - 1 : head - 1;
            slot = head;
          end else if (level >= cap) begin
            // full overwrite drops the oldest item
            slot = head;
            head = (head + 1 >= cap) ? head + 1 - cap : head + 1;
          end else begin
            slot = (head + level >= cap) ? head + level - cap : head + level;
          end
          ring[slot] = r.item_data;
          if (level < cap) level++;
          o.ok = 1'b1;
        end
      end else if (r.req_type == qsm_pkg::REQ_RECEIVE && level != 0 && cap != 0) begin
        o.item_out = ring[head];
        head  = (head + 1 >= cap) ? head + 1 - cap : head + 1;
        level--;
        o.ok  = 1'b1;
      end
      o.wake = o.ok;
    end else if (obj_kind == qsm_pkg::KIND_SEM) begin
      if (r.req_type <= qsm_pkg::REQ_OVERWRITE || r.req_type == qsm_pkg::REQ_GIVE) begin
        o.ok = release_token(r.requester);
      end else if (level != 0 && cap != 0) begin
        level--;
        o.ok = 1'b1;
      end
      o.wake = o.ok;
    end else if (obj_kind == qsm_pkg::KIND_MUTEX) begin
      if (r.req_type <= qsm_pkg::REQ_OVERWRITE || r.req_type == qsm_pkg::REQ_GIVE) begin
        o.ok   = release_token(r.requester);
        o.wake = o.ok;
      end else if (r.req_type == qsm_pkg::REQ_TAKE && r.requester != 0) begin
        if (owner == r.requester) begin
          if (nesting < NEST_MAX) begin
            nesting++;
            o.ok = 1'b1;
          end
        end else if (owner == 0 && level == 0) begin
          owner   = r.requester;
          nesting = 1;
          level   = 1;
          o.ok    = 1'b1;
        end
      end
    end
    if (obj_kind == qsm_pkg::KIND_MUTEX)
      o.waiting_count = (level == 0) ? 7'd1 : 7'd0;
    else if (obj_kind == qsm_pkg::KIND_QUEUE || obj_kind == qsm_pkg::KIND_SEM)
      o.waiting_count = CNT_W'(level);
    o.holder = owner;
    return o;
  endfunction

  function automatic qsm_pkg::rsp_t outcome(input bit ok, input int unsigned count,
                                            input logic [TASK_W-1:0] owner_id,
                                            input bit wake);
    qsm_pkg::rsp_t o;
    o               = '0;
    o.ok            = ok;
    o.waiting_count = CNT_W'(count);
    o.holder        = owner_id;
    o.wake          = wake;
    return o;
  endfunction

  function automatic void add_reg(input logic [CIDX_W-1:0] idx, input logic [CNT_W-1:0] val);
    script_row_t row;
    row         = '{default: '0};
    row.is_reg  = 1'b1;
    row.reg_idx = idx;
    row.reg_val = val;
    script.push_back(row);
  endfunction

  function automatic void add_req(input qsm_pkg::req_type_e kind,
                                  input logic [TASK_W-1:0] who,
                                  input logic [ITEM_W-1:0] data, input bit is_new,
                                  input bit typed = 1'b0,
                                  input qsm_pkg::rsp_t want = '0);
    script_row_t row;
    row                  = '{default: '0};
    row.req.req_type     = kind;
    row.req.requester    = who;
    row.req.item_data    = data;
    row.req.reset_is_new = is_new;
    row.typed            = typed;
    row.want             = want;
    script.push_back(row);
  endfunction

  // mostly well-formed traffic for the kind, with some noise
  function automatic qsm_pkg::req_t random_request(input logic [1:0] kind,
                                                   input int unsigned push_pct);
    qsm_pkg::req_t r;
    int unsigned   roll;
    roll           = $urandom_range(99);
    r.requester    = TASK_W'($urandom);
    r.item_data    = $urandom;
    r.reset_is_new = 1'($urandom);
    r.req_type     = qsm_pkg::req_type_e'($urandom_range(qsm_pkg::REQ_STATUS));
    case (kind)
      qsm_pkg::KIND_QUEUE: begin
        if (roll < push_pct)
          r.req_type = qsm_pkg::req_type_e'($urandom_range(qsm_pkg::REQ_OVERWRITE));
        else if (roll < 92) r.req_type = qsm_pkg::REQ_RECEIVE;
      end
      qsm_pkg::KIND_SEM: begin
        if (roll < push_pct)
          r.req_type = ($urandom_range(3) == 0) ?
                       qsm_pkg::req_type_e'($urandom_range(qsm_pkg::REQ_OVERWRITE)) :
                       qsm_pkg::REQ_GIVE;
        else if (roll < 92)
          r.req_type = $urandom_range(1) ? qsm_pkg::REQ_TAKE : qsm_pkg::REQ_RECEIVE;
      end
      qsm_pkg::KIND_MUTEX: begin
        // a few tasks contend, task 0 now and then
        r.requester = TASK_W'($urandom_range(3));
        if (roll < push_pct) r.req_type = qsm_pkg::REQ_TAKE;
        else if (roll < 92)
          r.req_type = ($urandom_range(7) == 0) ? qsm_pkg::REQ_SEND_BACK : qsm_pkg::REQ_GIVE;
      end
      default: ;
    endcase
    return r;
  endfunction

  // one request beat, with random idling ahead of it
  task automatic issue_request(input qsm_pkg::req_t r, input bit typed = 1'b0,
                               input qsm_pkg::rsp_t want = '0);
    qsm_pkg::rsp_t due;
    cfg_ch.valid <= 1'b0;
    while (!calm && $urandom_range(99) < IDLE_PCT) begin
      req_ch.valid <= 1'b0;
      @(posedge clk);
    end
    req_ch.valid <= 1'b1;
    req_ch.data  <= r;
    do @(posedge clk); while (!req_ch.ready);
    due = object_response(r);
    due_rsps.push_back(typed ? want : due);
  endtask

  // register write once every response has come back
  task automatic write_reg(input logic [CIDX_W-1:0] idx, input logic [CNT_W-1:0] val);
    qsm_pkg::cfg_t beat;
    beat.index   = idx;
    beat.wdata   = val;
    req_ch.valid <= 1'b0;
    while (due_rsps.size() != 0) @(posedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.data  <= beat;
    do @(posedge clk); while (!cfg_ch.ready);
    case (idx)
      qsm_pkg::CFG_OBJECT_KIND:   obj_kind = val[1:0];
      qsm_pkg::CFG_CAPACITY:      cap_reg  = val;
      qsm_pkg::CFG_INITIAL_COUNT: init_reg = val;
      default: ;
    endcase
    if (idx != qsm_pkg::CFG_NONE) set_up_object();
  endtask

  task automatic run_phase(input logic [1:0] kind, input logic [CNT_W-1:0] cap,
                           input logic [CNT_W-1:0] init, input int unsigned items,
                           input int unsigned push_pct);
    qsm_pkg::req_t r;
    write_reg(qsm_pkg::CFG_OBJECT_KIND, {5'($urandom), kind});
    write_reg(qsm_pkg::CFG_CAPACITY, cap);
    write_reg(qsm_pkg::CFG_INITIAL_COUNT, init);
    // mutex: nest up to the limit and one past it, one step down, then reset
    if (kind == qsm_pkg::KIND_MUTEX) begin
      r             = random_request(kind, 0);
      r.requester   = TASK_W'($urandom_range(255, 1));
      r.req_type    = qsm_pkg::REQ_TAKE;
      repeat (NEST_MAX + 1) issue_request(r);
      r.req_type    = qsm_pkg::REQ_GIVE;
      issue_request(r);
      r.req_type    = qsm_pkg::REQ_RESET;
      issue_request(r);
    end
    repeat (items) issue_request(random_request(kind, push_pct));
  endtask

  // response ready with random stalls
  always @(posedge clk) begin
    if (!rst_n) rsp_ch.ready <= 1'b0;
    else        rsp_ch.ready <= calm || ($urandom_range(99) >= IDLE_PCT);
  end

  task automatic check_field(input string name, input logic [ITEM_W-1:0] want,
                             input logic [ITEM_W-1:0] got);
    if (want !== got) begin
      $display("%0t: %s expected %0h, got %0h", $time, name, want, got);
      mismatches++;
    end
  endtask

  // compare each response beat with the oldest prediction
  always @(posedge clk) begin : rsp_check
    qsm_pkg::rsp_t want;
    if (rst_n && rsp_ch.valid && rsp_ch.ready) begin
      if (due_rsps.size() == 0) begin
        $display("%0t: response expected none, got %0h", $time, rsp_ch.data);
        mismatches++;
      end else begin
        want = due_rsps.pop_front();
        check_field("ok", ITEM_W'(want.ok), ITEM_W'(rsp_ch.data.ok));
        check_field("item_out", want.item_out, rsp_ch.data.item_out);
        check_field("waiting_count", ITEM_W'(want.waiting_count),
                    ITEM_W'(rsp_ch.data.waiting_count));
        check_field("holder", ITEM_W'(want.holder), ITEM_W'(rsp_ch.data.holder));
        check_field("wake", ITEM_W'(want.wake), ITEM_W'(rsp_ch.data.wake));
      end
    end
  end

  // watchdog on cycles with no beat on any channel
  always @(posedge clk) begin
    if (!rst_n || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  initial begin
    req_ch.valid <= 1'b0;
    req_ch.data  <= '0;
    cfg_ch.valid <= 1'b0;
    cfg_ch.data  <= '0;
    rst_n        <= 1'b0;

    obj_kind = qsm_pkg::KIND_QUEUE;
    cap_reg  = qsm_pkg::CAPACITY_RST;
    init_reg = qsm_pkg::INIT_CNT_RST;
    set_up_object();

    // queue kind straight out of reset, capacity 64
    add_req(qsm_pkg::REQ_STATUS,     8'h00, 32'h0000_0000, 1'b0,
            1'b1, outcome(1'b1, 0, 8'h00, 1'b0));
    add_req(qsm_pkg::REQ_RECEIVE,    8'h00, 32'h0000_0000, 1'b0,
            1'b1, outcome(1'b0, 0, 8'h00, 1'b0));
    add_req(qsm_pkg::REQ_TAKE,       8'h01, 32'h0000_0000, 1'b0,
            1'b1, outcome(1'b0, 0, 8'h00, 1'b0));
    add_req(qsm_pkg::REQ_GIVE,       8'h01, 32'h0000_0000, 1'b0,
            1'b1, outcome(1'b0, 0, 8'h00, 1'b0));
    add_req(qsm_pkg::REQ_SEND_BACK,  8'hff, 32'hffff_ffff, 1'b1,
            1'b1, outcome(1'b1, 1, 8'h00, 1'b1));
    add_req(qsm_pkg::REQ_SEND_FRONT, 8'h00, 32'h0000_0000, 1'b0);
    add_req(qsm_pkg::REQ_OVERWRITE,  8'h5a, 32'ha5a5_5a5a, 1'b0);
    add_req(qsm_pkg::REQ_RECEIVE,    8'h00, 32'h0000_0000, 1'b0);
    add_req(qsm_pkg::REQ_RESET,      8'h00, 32'h0000_0000, 1'b0,
            1'b1, outcome(1'b1, 0, 8'h00, 1'b1));
    add_req(qsm_pkg::REQ_RESET,      8'h00, 32'h0000_0000, 1'b1,
            1'b1, outcome(1'b1, 0, 8'h00, 1'b0));
    // capacity one: full after one send, overwrite replaces the oldest
    add_reg(qsm_pkg::CFG_CAPACITY, 7'd1);
    add_req(qsm_pkg::REQ_SEND_BACK,  8'h11, 32'h1234_5678, 1'b0);
    add_req(qsm_pkg::REQ_SEND_BACK,  8'h11, 32'h8765_4321, 1'b0,
            1'b1, outcome(1'b0, 1, 8'h00, 1'b0));
    add_req(qsm_pkg::REQ_OVERWRITE,  8'h11, 32'hdead_beef, 1'b0);
    add_req(qsm_pkg::REQ_RECEIVE,    8'h11, 32'h0000_0000, 1'b0);
    // zero capacity refuses sends and receives
    add_reg(qsm_pkg::CFG_CAPACITY, 7'd0);
    add_req(qsm_pkg::REQ_SEND_BACK,  8'h22, 32'h0bad_f00d, 1'b0,
            1'b1, outcome(1'b0, 0, 8'h00, 1'b0));
    add_req(qsm_pkg::REQ_RECEIVE,    8'h22, 32'h0000_0000, 1'b0,
            1'b1, outcome(1'b0, 0, 8'h00, 1'b0));
    // unused kind only answers reset and status
    add_reg(qsm_pkg::CFG_OBJECT_KIND, CNT_W'(KIND_UNUSED));
    add_req(qsm_pkg::REQ_GIVE,       8'h01, 32'h0000_0000, 1'b0,
            1'b1, outcome(1'b0, 0, 8'h00, 1'b0));
    add_req(qsm_pkg::REQ_STATUS,     8'h01, 32'h0000_0000, 1'b0,
            1'b1, outcome(1'b1, 0, 8'h00, 1'b0));
    // semaphore with capacity and initial count above the ring size
    add_reg(qsm_pkg::CFG_OBJECT_KIND, CNT_W'(qsm_pkg::KIND_SEM));
    add_reg(qsm_pkg::CFG_CAPACITY, 7'd127);
    add_reg(qsm_pkg::CFG_INITIAL_COUNT, 7'd127);
    add_req(qsm_pkg::REQ_GIVE,       8'h00, 32'h0000_0000, 1'b0,
            1'b1, outcome(1'b0, 64, 8'h00, 1'b0));
    add_req(qsm_pkg::REQ_TAKE,       8'h00, 32'h0000_0000, 1'b0,
            1'b1, outcome(1'b1, 63, 8'h00, 1'b1));
    add_req(qsm_pkg::REQ_RECEIVE,    8'h00, 32'h0000_0000, 1'b0,
            1'b1, outcome(1'b1, 62, 8'h00, 1'b1));
    add_req(qsm_pkg::REQ_SEND_FRONT, 8'h00, 32'hffff_ffff, 1'b0,
            1'b1, outcome(1'b1, 63, 8'h00, 1'b1));
    // mutex: no task context, take, foreign give, receive, send as give
    add_reg(qsm_pkg::CFG_OBJECT_KIND, CNT_W'(qsm_pkg::KIND_MUTEX));
    add_req(qsm_pkg::REQ_TAKE,       8'h00, 32'h0000_0000, 1'b0,
            1'b1, outcome(1'b0, 1, 8'h00, 1'b0));
    add_req(qsm_pkg::REQ_TAKE,       8'hff, 32'h0000_0000, 1'b0,
            1'b1, outcome(1'b1, 0, 8'hff, 1'b0));
    add_req(qsm_pkg::REQ_GIVE,       8'h03, 32'h0000_0000, 1'b0,
            1'b1, outcome(1'b0, 0, 8'hff, 1'b0));
    add_req(qsm_pkg::REQ_RECEIVE,    8'hff, 32'h0000_0000, 1'b0,
            1'b1, outcome(1'b0, 0, 8'hff, 1'b0));
    add_req(qsm_pkg::REQ_SEND_BACK,  8'hff, 32'h0000_0000, 1'b0,
            1'b1, outcome(1'b1, 1, 8'h00, 1'b1));
    // index with no register behind it
    add_reg(qsm_pkg::CFG_NONE, 7'd0);

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // scripted corner cases
    foreach (script[i]) begin
      if (script[i].is_reg) write_reg(script[i].reg_idx, script[i].reg_val);
      else issue_request(script[i].req, script[i].typed, script[i].want);
    end

    // random phases across kinds and sizes
    run_phase(qsm_pkg::KIND_QUEUE, 7'd4, 7'd0, 20, 55);
    calm = 1'b1;
    run_phase(qsm_pkg::KIND_QUEUE, 7'd127, 7'd0, 25, 85);
    calm = 1'b0;
    run_phase(qsm_pkg::KIND_QUEUE, 7'd1, 7'd127, 8, 50);
    run_phase(qsm_pkg::KIND_SEM, 7'd3, 7'd2, 15, 45);
    run_phase(qsm_pkg::KIND_SEM, 7'd2, 7'd9, 10, 45);
    run_phase(qsm_pkg::KIND_SEM, 7'd64, 7'd0, 10, 50);
    run_phase(qsm_pkg::KIND_MUTEX, 7'd1, 7'd0, 20, 50);
    run_phase(KIND_UNUSED, 7'd0, 7'd0, 5, 50);

    // drain, then watch for any stray beat
    req_ch.valid <= 1'b0;
    cfg_ch.valid <= 1'b0;
    while (due_rsps.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0)
      $display("No mismatches found");
    else
      $display("Mismatches found");
    $finish;
  end

endmodule

/* queue_semaphore_mutex_engine_top.f */
sv/qsm_pkg.sv
sv/qsm_if.sv
sv/queue_semaphore_mutex_engine_top.sv
sv/qsm_checker.sv
tb/sv/tb.sv
